// ===== design/mi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse package
// Microcode format, step addresses and the control store of the sequencer.
// ----------------------------------------------------------------------------
package mi_pkg;

	localparam int STEP_W = 4;

	localparam logic [31:0] MODULUS_RESET = 32'h7FFF_FFFF;

	localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_CHECK  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_TEST   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_UP     = 4'd3;
	localparam logic [STEP_W-1:0] STEP_DOWN   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_SWAP   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_FINISH = 4'd6;
	localparam logic [STEP_W-1:0] STEP_SIGN   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_ERR    = 4'd9;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_INIT_DIV,
		OP_SHIFT_UP,
		OP_SUB_DOWN,
		OP_SWAP,
		OP_FOLD,
		OP_NEGATE,
		OP_EMIT_OK,
		OP_EMIT_ERR
	} op_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_MOD_SMALL,
		COND_R1_ZERO,
		COND_CAN_UP,
		COND_K_ZERO,
		COND_GCD_NOT_ONE,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] jump_true;
		logic [STEP_W-1:0] jump_false;
	} uop_t;

	function automatic uop_t ucode(input logic [STEP_W-1:0] pc);
		uop_t u;
		case (pc)
			STEP_IDLE:   u = '{OP_LOAD,     COND_IN_VALID,    STEP_CHECK,  STEP_IDLE};
			STEP_CHECK:  u = '{OP_NOP,      COND_MOD_SMALL,   STEP_ERR,    STEP_TEST};
			STEP_TEST:   u = '{OP_INIT_DIV, COND_R1_ZERO,     STEP_FINISH, STEP_UP};
			STEP_UP:     u = '{OP_SHIFT_UP, COND_CAN_UP,      STEP_UP,     STEP_DOWN};
			STEP_DOWN:   u = '{OP_SUB_DOWN, COND_K_ZERO,      STEP_SWAP,   STEP_DOWN};
			STEP_SWAP:   u = '{OP_SWAP,     COND_ALWAYS,      STEP_TEST,   STEP_TEST};
			STEP_FINISH: u = '{OP_FOLD,     COND_GCD_NOT_ONE, STEP_ERR,    STEP_SIGN};
			STEP_SIGN:   u = '{OP_NEGATE,   COND_ALWAYS,      STEP_EMIT,   STEP_EMIT};
			STEP_EMIT:   u = '{OP_EMIT_OK,  COND_OUT_FREE,    STEP_IDLE,   STEP_EMIT};
			STEP_ERR:    u = '{OP_EMIT_ERR, COND_OUT_FREE,    STEP_IDLE,   STEP_ERR};
			default:     u = '{OP_NOP,      COND_ALWAYS,      STEP_IDLE,   STEP_IDLE};
		endcase
		return u;
	endfunction

endpackage

// ===== design/modular_inverse_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse
// Extended Euclid inverse of value modulo a configured modulus, run by a
// microcoded sequencer over a shift-and-subtract divider.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------
//  in       | in_valid / in_ready   | value
//  out      | out_valid / out_ready | inverse, no_inverse
//  cfg      | cfg_we                | cfg_wdata (modulus)
//
// One transaction at a time. Each Euclid division step shifts the divisor up
// by k, the index of the top set bit of its quotient (0 for quotients of 0
// or 1), then the divider takes one quotient bit per cycle on the way down.
// After reset the modulus is 2^31-1 and the sequencer is idle. A stalled output
// holds the finished result in the output register while the next transaction
// is accepted and worked on.
// ----------------------------------------------------------------------------
module modular_inverse_top
	import mi_pkg::*;
#(
	parameter int DATA_WIDTH = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] inverse,
	output logic                  no_inverse,
	input  logic                  cfg_we,
	input  logic [DATA_WIDTH-1:0] cfg_wdata
);

	localparam int W  = DATA_WIDTH;
	localparam int KW = $clog2(DATA_WIDTH + 1);
	localparam logic [W-1:0] MOD_RESET = W'(MODULUS_RESET);

	logic [STEP_W-1:0] pc_q;
	logic [W-1:0]      modulus_q;
	logic [W-1:0]      r0_q, r1_q, s0_q, s1_q, rem_q, acc_q;
	logic              n0_q, n1_q;
	logic [W:0]        div_q, sh_q;
	logic [KW-1:0]     k_q;
	logic              out_valid_q, no_inverse_q;
	logic [W-1:0]      inverse_q;

	uop_t uop;
	logic can_up, fits, take, out_free;

	assign uop      = ucode(pc_q);
	assign in_ready = (pc_q == STEP_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign can_up   = ({div_q, 1'b0} <= {2'b00, rem_q});
	assign fits     = (div_q <= {1'b0, rem_q});

	always_comb begin
		case (uop.cond)
			COND_ALWAYS:      take = 1'b1;
			COND_IN_VALID:    take = in_valid;
			COND_MOD_SMALL:   take = (modulus_q[W-1:1] == '0);
			COND_R1_ZERO:     take = (r1_q == '0);
			COND_CAN_UP:      take = can_up;
			COND_K_ZERO:      take = (k_q == '0);
			COND_GCD_NOT_ONE: take = (r0_q != W'(1));
			COND_OUT_FREE:    take = out_free;
			default:          take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			modulus_q   <= MOD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= take ? uop.jump_true : uop.jump_false;
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
			if ((uop.op == OP_EMIT_OK || uop.op == OP_EMIT_ERR) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uop.op)
			OP_LOAD: begin
				if (in_valid) begin
					r0_q <= modulus_q;
					r1_q <= value;
					s0_q <= '0;
					s1_q <= W'(1);
					n0_q <= 1'b0;
					n1_q <= 1'b0;
				end
			end
			OP_INIT_DIV: begin
				div_q <= {1'b0, r1_q};
				sh_q  <= {1'b0, s1_q};
				rem_q <= r0_q;
				acc_q <= s0_q;
				k_q   <= '0;
			end
			OP_SHIFT_UP: begin
				if (can_up) begin
					div_q <= {div_q[W-1:0], 1'b0};
					sh_q  <= {sh_q[W-1:0], 1'b0};
					k_q   <= k_q + KW'(1);
				end
			end
			OP_SUB_DOWN: begin
				if (fits) begin
					rem_q <= rem_q - div_q[W-1:0];
					acc_q <= acc_q + sh_q[W-1:0];
				end
				if (k_q != '0) begin
					div_q <= {1'b0, div_q[W:1]};
					sh_q  <= {1'b0, sh_q[W:1]};
					k_q   <= k_q - KW'(1);
				end
			end
			OP_SWAP: begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				s0_q <= s1_q;
				s1_q <= acc_q;
				n0_q <= n1_q;
				n1_q <= !n1_q;
			end
			OP_FOLD: begin
				if (s0_q >= modulus_q) begin
					s0_q <= s0_q - modulus_q;
				end
			end
			OP_NEGATE: begin
				if (n0_q && s0_q != '0) begin
					s0_q <= modulus_q - s0_q;
				end
			end
			OP_EMIT_OK: begin
				if (out_free) begin
					inverse_q    <= s0_q;
					no_inverse_q <= 1'b0;
				end
			end
			OP_EMIT_ERR: begin
				if (out_free) begin
					inverse_q    <= '0;
					no_inverse_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign inverse    = inverse_q;
	assign no_inverse = no_inverse_q;

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> pc_q == STEP_CHECK)
		else $error("Accepted transaction did not enter the modulus check.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_inverse |-> inverse == '0)
		else $error("Error result carries a nonzero inverse.");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == STEP_SWAP |-> rem_q < r1_q)
		else $error("Division remainder is not below the divisor.");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == STEP_TEST && r1_q != '0 |=> k_q == '0 && pc_q == STEP_UP)
		else $error("Division did not start from an unshifted divisor.");

endmodule
